@@ hw/rtl/eph_pkg.sv @@
// Shared types and constants for the Ethernet/IPv4 header field filter.
package eph_pkg;

   localparam int unsigned POS_W      = 11;
   localparam int unsigned IHL_W      = 4;
   localparam int unsigned FIELD_CNT  = 6;
   localparam int unsigned CSR_DATA_W = 64;
   localparam int unsigned CSR_ADDR_W = 6;
   localparam int unsigned CSR_IDX_W  = 3;

   localparam logic [POS_W-1:0] POS_MAX    = 11'd2047;
   localparam logic [POS_W-1:0] DST_MAC_AT = 11'd0;
   localparam logic [POS_W-1:0] SRC_MAC_AT = 11'd6;
   localparam logic [POS_W-1:0] SRC_IP_AT  = 11'd26;
   localparam logic [POS_W-1:0] DST_IP_AT  = 11'd30;
   localparam logic [POS_W-1:0] L2_BYTES   = 11'd14;
   localparam logic [POS_W-1:0] MAC_BYTES  = 11'd6;
   localparam logic [POS_W-1:0] IP_BYTES   = 11'd4;

   // Bit positions in the enable and coverage vectors
   localparam int unsigned FLD_SRC_MAC  = 0;
   localparam int unsigned FLD_DST_MAC  = 1;
   localparam int unsigned FLD_SRC_IP   = 2;
   localparam int unsigned FLD_DST_IP   = 3;
   localparam int unsigned FLD_SRC_PORT = 4;
   localparam int unsigned FLD_DST_PORT = 5;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_MATCH_ENABLES = 3'd0,
      REG_WANT_SRC_MAC  = 3'd1,
      REG_WANT_DST_MAC  = 3'd2,
      REG_WANT_SRC_IP   = 3'd3,
      REG_WANT_DST_IP   = 3'd4,
      REG_WANT_SRC_PORT = 3'd5,
      REG_WANT_DST_PORT = 3'd6
   } reg_index_type;

   typedef struct packed {
      logic [3:0]  match_enables;
      logic [47:0] want_src_mac;
      logic [47:0] want_dst_mac;
      logic [31:0] want_src_ip;
      logic [31:0] want_dst_ip;
      logic [15:0] want_src_port;
      logic [15:0] want_dst_port;
   } filter_cfg_type;

   typedef struct packed {
      logic drop;
      logic truncated;
   } verdict_type;

endpackage

@@ hw/rtl/eph_channels.sv @@
// Valid/ready channel interfaces for frame bytes in and verdicts out.
interface eph_req_if;
   import eph_pkg::*;
   logic       valid;
   logic       ready;
   logic [7:0] frame_byte;
   logic       end_of_frame;

   modport source (output valid, output frame_byte, output end_of_frame, input ready);
   modport sink   (input valid, input frame_byte, input end_of_frame, output ready);
endinterface

interface eph_rsp_if;
   import eph_pkg::*;
   logic valid;
   logic ready;
   logic drop;
   logic truncated;

   modport source (output valid, output drop, output truncated, input ready);
   modport sink   (input valid, input drop, input truncated, output ready);
endinterface

@@ hw/rtl/eph_csr.sv @@
// APB-style register file holding the filter match configuration.
module eph_csr
   import eph_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output filter_cfg_type        cfg
);

   filter_cfg_type          cfg_ff;
   logic [CSR_IDX_W-1:0]    reg_idx;
   logic                    wr_en;

   // Registers sit on 8-byte boundaries
   assign reg_idx    = csr_paddr[CSR_ADDR_W-1:CSR_ADDR_W-CSR_IDX_W];
   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign cfg        = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (wr_en) begin
         unique case (reg_idx)
            REG_MATCH_ENABLES: cfg_ff.match_enables <= csr_pwdata[3:0];
            REG_WANT_SRC_MAC:  cfg_ff.want_src_mac  <= csr_pwdata[47:0];
            REG_WANT_DST_MAC:  cfg_ff.want_dst_mac  <= csr_pwdata[47:0];
            REG_WANT_SRC_IP:   cfg_ff.want_src_ip   <= csr_pwdata[31:0];
            REG_WANT_DST_IP:   cfg_ff.want_dst_ip   <= csr_pwdata[31:0];
            REG_WANT_SRC_PORT: cfg_ff.want_src_port <= csr_pwdata[15:0];
            REG_WANT_DST_PORT: cfg_ff.want_dst_port <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_MATCH_ENABLES: csr_prdata = {60'd0, cfg_ff.match_enables};
         REG_WANT_SRC_MAC:  csr_prdata = {16'd0, cfg_ff.want_src_mac};
         REG_WANT_DST_MAC:  csr_prdata = {16'd0, cfg_ff.want_dst_mac};
         REG_WANT_SRC_IP:   csr_prdata = {32'd0, cfg_ff.want_src_ip};
         REG_WANT_DST_IP:   csr_prdata = {32'd0, cfg_ff.want_dst_ip};
         REG_WANT_SRC_PORT: csr_prdata = {48'd0, cfg_ff.want_src_port};
         REG_WANT_DST_PORT: csr_prdata = {48'd0, cfg_ff.want_dst_port};
         default:           csr_prdata = '0;
      endcase
   end

endmodule

@@ hw/rtl/eph_match.sv @@
// Per-byte header compare: frame position, IHL capture, mismatch and coverage state.
module eph_match
   import eph_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           step,
   input  logic [7:0]     frame_byte,
   input  logic           end_of_frame,
   input  filter_cfg_type cfg,
   output verdict_type    verdict
);

   logic [POS_W-1:0]     pos_ff, pos_in;
   logic [IHL_W-1:0]     ihl_ff, ihl_in;
   logic                 mismatch_ff, mismatch_in;
   logic [FIELD_CNT-1:0] covered_ff, covered_in;

   logic [IHL_W-1:0]     ihl_cur;
   logic [POS_W-1:0]     port_at;
   logic [POS_W-1:0]     off_smac, off_dmac, off_sip, off_dip, off_port;
   logic                 in_smac, in_dmac, in_sip, in_dip, in_sport, in_dport;
   logic [7:0]           exp_smac, exp_dmac, exp_sip, exp_dip, exp_sport, exp_dport;
   logic                 en_sport, en_dport;
   logic                 mis_now;
   logic [FIELD_CNT-1:0] cov_now, needed, covered_all;
   logic                 mismatch_all, trunc;

   function automatic logic [7:0] mac_byte(input logic [47:0] w, input logic [2:0] k);
      logic [7:0] b;
      unique case (k)
         3'd0:    b = w[47:40];
         3'd1:    b = w[39:32];
         3'd2:    b = w[31:24];
         3'd3:    b = w[23:16];
         3'd4:    b = w[15:8];
         3'd5:    b = w[7:0];
         default: b = '0;
      endcase
      return b;
   endfunction

   function automatic logic [7:0] ip_byte(input logic [31:0] w, input logic [1:0] k);
      logic [7:0] b;
      unique case (k)
         2'd0: b = w[31:24];
         2'd1: b = w[23:16];
         2'd2: b = w[15:8];
         2'd3: b = w[7:0];
      endcase
      return b;
   endfunction

   always_comb begin
      // IHL of the byte at offset 14 applies to that same byte
      ihl_cur  = (pos_ff == L2_BYTES) ? frame_byte[IHL_W-1:0] : ihl_ff;
      port_at  = L2_BYTES + {5'd0, ihl_cur, 2'b00};

      off_smac = pos_ff - SRC_MAC_AT;
      off_dmac = pos_ff - DST_MAC_AT;
      off_sip  = pos_ff - SRC_IP_AT;
      off_dip  = pos_ff - DST_IP_AT;
      off_port = pos_ff - port_at;

      in_smac  = (pos_ff >= SRC_MAC_AT) && (off_smac < MAC_BYTES);
      in_dmac  = (off_dmac < MAC_BYTES);
      in_sip   = (pos_ff >= SRC_IP_AT) && (off_sip < IP_BYTES);
      in_dip   = (pos_ff >= DST_IP_AT) && (off_dip < IP_BYTES);
      in_sport = (pos_ff >= port_at) && (off_port[POS_W-1:1] == '0);
      in_dport = (pos_ff >= port_at) && (off_port[POS_W-1:1] == 10'd1);

      exp_smac  = mac_byte(cfg.want_src_mac, off_smac[2:0]);
      exp_dmac  = mac_byte(cfg.want_dst_mac, off_dmac[2:0]);
      exp_sip   = ip_byte(cfg.want_src_ip, off_sip[1:0]);
      exp_dip   = ip_byte(cfg.want_dst_ip, off_dip[1:0]);
      exp_sport = off_port[0] ? cfg.want_src_port[7:0] : cfg.want_src_port[15:8];
      exp_dport = off_port[0] ? cfg.want_dst_port[7:0] : cfg.want_dst_port[15:8];

      en_sport = (cfg.want_src_port != '0);
      en_dport = (cfg.want_dst_port != '0);

      mis_now = (in_smac && cfg.match_enables[FLD_SRC_MAC] && exp_smac != frame_byte)
             || (in_dmac && cfg.match_enables[FLD_DST_MAC] && exp_dmac != frame_byte)
             || (in_sip && cfg.match_enables[FLD_SRC_IP] && exp_sip != frame_byte)
             || (in_dip && cfg.match_enables[FLD_DST_IP] && exp_dip != frame_byte)
             || (in_sport && en_sport && exp_sport != frame_byte)
             || (in_dport && en_dport && exp_dport != frame_byte);

      // Mark a field covered on its last byte
      cov_now = '0;
      cov_now[FLD_SRC_MAC]  = (pos_ff == SRC_MAC_AT + MAC_BYTES - 11'd1);
      cov_now[FLD_DST_MAC]  = (pos_ff == DST_MAC_AT + MAC_BYTES - 11'd1);
      cov_now[FLD_SRC_IP]   = (pos_ff == SRC_IP_AT + IP_BYTES - 11'd1);
      cov_now[FLD_DST_IP]   = (pos_ff == DST_IP_AT + IP_BYTES - 11'd1);
      cov_now[FLD_SRC_PORT] = (pos_ff == port_at + 11'd1);
      cov_now[FLD_DST_PORT] = (pos_ff == port_at + 11'd3);

      mismatch_all = mismatch_ff | mis_now;
      covered_all  = covered_ff | cov_now;

      needed = {en_dport, en_sport, cfg.match_enables};
      trunc  = |(needed & ~covered_all);

      verdict.drop      = mismatch_all | trunc;
      verdict.truncated = trunc;

      if (end_of_frame) begin
         pos_in      = '0;
         ihl_in      = '0;
         mismatch_in = 1'b0;
         covered_in  = '0;
      end else begin
         pos_in      = (pos_ff < POS_MAX) ? pos_ff + 11'd1 : pos_ff;
         ihl_in      = ihl_cur;
         mismatch_in = mismatch_all;
         covered_in  = covered_all;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= '0;
         ihl_ff      <= '0;
         mismatch_ff <= 1'b0;
         covered_ff  <= '0;
      end else if (step) begin
         pos_ff      <= pos_in;
         ihl_ff      <= ihl_in;
         mismatch_ff <= mismatch_in;
         covered_ff  <= covered_in;
      end
   end

endmodule

@@ hw/rtl/ethernet_ip_port_header_filter_top.sv @@
// Top level: input byte register, header compare, verdict register and APB registers.
// The rsp verdict register loads as the end-of-frame byte leaves the input register.
// Throughput: one frame byte per cycle, set by the single input register feeding the
// compare logic; only a stalled verdict with a second end-of-frame byte waiting holds req.
// Reset (synchronous, active high) zeroes valid, match and config state for a new frame.
module ethernet_ip_port_header_filter_top
   import eph_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   eph_req_if.sink               req,
   eph_rsp_if.source             rsp,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   filter_cfg_type cfg;
   verdict_type    verdict;

   logic       s1_valid_ff;
   logic [7:0] s1_byte_ff;
   logic       s1_eof_ff;
   logic       rsp_valid_ff;
   logic       drop_ff;
   logic       trunc_ff;
   logic       out_free;
   logic       s1_go;

   eph_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   eph_match u_match (
      .clock        (clock),
      .reset        (reset),
      .step         (s1_go),
      .frame_byte   (s1_byte_ff),
      .end_of_frame (s1_eof_ff),
      .cfg          (cfg),
      .verdict      (verdict)
   );

   // Only an end-of-frame byte needs room in the verdict register
   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign s1_go     = s1_valid_ff && (!s1_eof_ff || out_free);
   assign req.ready = !s1_valid_ff || s1_go;

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.drop      = drop_ff;
   assign rsp.truncated = trunc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req.ready) begin
         s1_valid_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req.ready && req.valid) begin
         s1_byte_ff <= req.frame_byte;
         s1_eof_ff  <= req.end_of_frame;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_go && s1_eof_ff) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_go && s1_eof_ff) begin
         drop_ff  <= verdict.drop;
         trunc_ff <= verdict.truncated;
      end
   end

   a_eof_gives_verdict: assert property (@(posedge clock) disable iff (reset)
      s1_go && s1_eof_ff |=> rsp_valid_ff)
      else $error("end-of-frame transaction did not load a verdict");

   a_trunc_implies_drop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (!trunc_ff || drop_ff))
      else $error("truncated verdict without drop");

   a_stall_only_on_full: assert property (@(posedge clock) disable iff (reset)
      !req.ready |-> (s1_valid_ff && s1_eof_ff && rsp_valid_ff && !rsp.ready))
      else $error("input held without a blocked verdict");

   a_no_verdict_from_mid_frame: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff && !(s1_go && s1_eof_ff) |=> !rsp_valid_ff)
      else $error("verdict raised without an end-of-frame transaction");

endmodule
